FILE: src/vertex_dedup_index_remap_assert.svh
// Assertion macros for the checker file of the vertex dedup block.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef VERTEX_DEDUP_INDEX_REMAP_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_REMAP_ASSERT_SVH

// Same-cycle implication.
`define VDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VDR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vdr_pkg.sv
// ----------------------------------------------------------------------------
// vdr_pkg
// Types, constants and the float compare shared by the vertex dedup block.
// ----------------------------------------------------------------------------
package vdr_pkg;

	// Number of compare cells in the search chain, and its log2.
	localparam int VDR_CELLS  = 16;
	localparam int VDR_CELL_W = 4;

	typedef enum logic {
		VDR_KIND_VERTEX = 1'b0,
		VDR_KIND_CORNER = 1'b1
	} vdr_kind_t;

	typedef struct packed {
		vdr_kind_t   kind;
		logic        new_mesh;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
		logic [15:0] corner_index;
	} vdr_item_t;

	typedef struct packed {
		logic [15:0] remapped_index;
		logic        was_merged;
	} vdr_res_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vdr_vertex_t;

	typedef enum logic [2:0] {
		VDR_IDLE,
		VDR_SEARCH,
		VDR_WRITE,
		VDR_CADDR,
		VDR_CDATA
	} vdr_state_t;

	// IEEE single equality: NaN equals nothing, and +0 equals -0.
	function automatic logic vdr_feq(input logic [31:0] a, input logic [31:0] b);
		logic a_nan;
		logic b_nan;
		a_nan = (a[30:0] > 31'h7F80_0000);
		b_nan = (b[30:0] > 31'h7F80_0000);
		return !a_nan && !b_nan && ((a == b) || ((a[30:0] | b[30:0]) == 31'd0));
	endfunction

endpackage

FILE: src/vdr_ram.sv
// ----------------------------------------------------------------------------
// vdr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module vdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/vdr_cell.sv
// ----------------------------------------------------------------------------
// vdr_cell
// One compare cell: owns one bank of the vertex store, compares a row entry
// against the query and passes the row and the running match to its neighbor.
// ----------------------------------------------------------------------------
module vdr_cell #(
	parameter int ROWS    = 64,
	parameter int ROW_W   = 6,
	parameter int IDX_W   = 10,
	parameter int CELL_ID = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vdr_pkg::vdr_vertex_t query,
	input  logic [IDX_W-1:0]    qidx,
	input  logic                wr_en,
	input  logic [ROW_W-1:0]    wr_row,
	input  vdr_pkg::vdr_vertex_t wr_data,
	input  logic                valid_in,
	input  logic [ROW_W-1:0]    row_in,
	input  logic                found_in,
	input  logic [IDX_W-1:0]    fidx_in,
	output logic                valid_out,
	output logic [ROW_W-1:0]    row_out,
	output logic                found_out,
	output logic [IDX_W-1:0]    fidx_out
);

	localparam int GW = ROW_W + vdr_pkg::VDR_CELL_W;

	vdr_pkg::vdr_vertex_t entry;
	logic                 valid_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     fidx_q;
	logic [GW-1:0]        gidx;
	logic                 hit;

	vdr_ram #(
		.WIDTH($bits(vdr_pkg::vdr_vertex_t)),
		.DEPTH(ROWS)
	) u_bank (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_row),
		.wdata(wr_data),
		.raddr(row_in),
		.rdata(entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			found_q  <= found_in || hit;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_in;
		fidx_q <= found_in ? fidx_in : gidx[IDX_W-1:0];
	end

	// Entries at or above the query index belong to no earlier vertex of
	// this mesh, so they never count as a match.
	assign gidx = {row_s1, vdr_pkg::VDR_CELL_W'(CELL_ID)};
	assign hit  = valid_s1 && (gidx < GW'(qidx)) &&
		vdr_pkg::vdr_feq(entry.x, query.x) &&
		vdr_pkg::vdr_feq(entry.y, query.y) &&
		vdr_pkg::vdr_feq(entry.z, query.z);

	assign valid_out = valid_s1;
	assign row_out   = row_s1;
	assign found_out = found_q;
	assign fidx_out  = fidx_q;

endmodule

FILE: src/vertex_dedup_index_remap.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap
// Exact vertex deduplication with triangle corner index remapping.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (item_valid, item_stall, item). A vertex
// request stores its coordinates and finds the lowest earlier vertex of the
// mesh with equal coordinates; it produces no result. A corner request
// produces one result on the res channel (res_valid, res_stall, res) with
// the canonical index of the named vertex, or the index itself when it names no stored vertex.
// The store is split over a chain of 16 compare cells. Cell k holds vertices
// k, k+16, k+32 and so on; a row address enters the chain every cycle and the
// match travels along it. A vertex at index n searches ceil(n/16) rows at
// most, fewer when a match is found early. A corner request passes through the
// CADDR and CDATA states and loads the result register from CDATA once that
// register is free. One request is in work at a time.
// The result register frees the input side: while a result waits under
// res_stall, vertex requests go on; a corner request waits for the register.
// Reset empties the store (vertex count zero) and clears both channels.
// ----------------------------------------------------------------------------
module vertex_dedup_index_remap #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  vdr_pkg::vdr_item_t  item,
	output logic                res_valid,
	input  logic                res_stall,
	output vdr_pkg::vdr_res_t   res
);

	localparam int CELLS = vdr_pkg::VDR_CELLS;
	localparam int CW    = vdr_pkg::VDR_CELL_W;
	localparam int ROWS  = (MAX_VERTICES + CELLS - 1) / CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int NR_W  = $clog2(ROWS + 1);
	localparam int GW    = ROW_W + CW;

	vdr_pkg::vdr_state_t  state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	vdr_pkg::vdr_vertex_t query_q;
	logic [15:0]          ci_q;
	logic [NR_W-1:0]      nrows_q, iss_q, ret_q;
	logic                 srch_found_q;
	logic [IDX_W-1:0]     canon_q;
	logic                 ret_vld_q;
	logic                 res_valid_q;
	vdr_pkg::vdr_res_t    res_q;

	logic                 accept;
	logic [CNT_W-1:0]     cnt_base;
	logic [CNT_W:0]       rows_sum;
	logic                 vtx_take;
	logic                 issue;
	logic                 srch_done;
	logic                 res_load;
	logic [IDX_W-1:0]     canon;
	logic [GW-1:0]        wr_pos;
	logic [IDX_W-1:0]     map_rdata;
	logic                 in_range;
	logic [15:0]          remap;

	logic [CELLS:0]       lk_valid;
	logic [CELLS:0]       lk_found;
	logic [ROW_W-1:0]     lk_row  [CELLS+1];
	logic [IDX_W-1:0]     lk_fidx [CELLS+1];

	assign accept   = item_valid && !item_stall;
	assign cnt_base = item.new_mesh ? '0 : cnt_q;
	assign rows_sum = {1'b0, cnt_base} + (CNT_W + 1)'(CELLS - 1);
	// A full store ignores a vertex that does not start a new mesh.
	assign vtx_take = (item.kind == vdr_pkg::VDR_KIND_VERTEX) &&
		(cnt_base != CNT_W'(MAX_VERTICES));

	assign issue     = (state_q == vdr_pkg::VDR_SEARCH) && (iss_q != nrows_q) && !srch_found_q;
	assign srch_done = (ret_q == iss_q) && (srch_found_q || (iss_q == nrows_q));
	assign canon     = srch_found_q ? canon_q : idx_q;
	assign wr_pos    = GW'(idx_q);

	assign in_range = {1'b0, ci_q} < 17'(cnt_q);
	assign remap    = in_range ? 16'(map_rdata) : ci_q;

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		case (state_q)
			vdr_pkg::VDR_IDLE: begin
				if (accept) begin
					if (item.kind == vdr_pkg::VDR_KIND_CORNER) begin
						state_d = vdr_pkg::VDR_CADDR;
					end else if (vtx_take) begin
						state_d = vdr_pkg::VDR_SEARCH;
					end
				end
			end
			vdr_pkg::VDR_SEARCH: begin
				if (srch_done) begin
					state_d = vdr_pkg::VDR_WRITE;
				end
			end
			vdr_pkg::VDR_WRITE: begin
				state_d = vdr_pkg::VDR_IDLE;
			end
			vdr_pkg::VDR_CADDR: begin
				state_d = vdr_pkg::VDR_CDATA;
			end
			vdr_pkg::VDR_CDATA: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = vdr_pkg::VDR_IDLE;
				end
			end
			default: begin
				state_d = vdr_pkg::VDR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vdr_pkg::VDR_IDLE;
			cnt_q        <= '0;
			iss_q        <= '0;
			ret_q        <= '0;
			srch_found_q <= 1'b0;
			ret_vld_q    <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_vld_q <= lk_valid[CELLS];
			if (state_q == vdr_pkg::VDR_IDLE) begin
				iss_q        <= '0;
				ret_q        <= '0;
				srch_found_q <= 1'b0;
			end else begin
				if (issue) begin
					iss_q <= iss_q + 1'b1;
				end
				if (ret_vld_q) begin
					ret_q <= ret_q + 1'b1;
					if (lk_found[CELLS]) begin
						srch_found_q <= 1'b1;
					end
				end
			end
			if (state_q == vdr_pkg::VDR_WRITE) begin
				cnt_q <= CNT_W'(idx_q) + 1'b1;
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= cnt_base[IDX_W-1:0];
			nrows_q <= NR_W'(rows_sum >> CW);
			query_q <= '{x: item.coord_x, y: item.coord_y, z: item.coord_z};
			ci_q    <= item.corner_index;
		end
		// Rows come back in order, so the first match seen is the lowest.
		if (ret_vld_q && lk_found[CELLS] && !srch_found_q) begin
			canon_q <= lk_fidx[CELLS];
		end
		if (res_load) begin
			res_q.remapped_index <= remap;
			res_q.was_merged     <= (remap != ci_q);
		end
	end

	assign lk_valid[0] = issue;
	assign lk_row[0]   = iss_q[ROW_W-1:0];
	assign lk_found[0] = 1'b0;
	assign lk_fidx[0]  = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		vdr_cell #(
			.ROWS   (ROWS),
			.ROW_W  (ROW_W),
			.IDX_W  (IDX_W),
			.CELL_ID(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.query    (query_q),
			.qidx     (idx_q),
			.wr_en    ((state_q == vdr_pkg::VDR_WRITE) && (wr_pos[CW-1:0] == CW'(k))),
			.wr_row   (wr_pos[GW-1:CW]),
			.wr_data  (query_q),
			.valid_in (lk_valid[k]),
			.row_in   (lk_row[k]),
			.found_in (lk_found[k]),
			.fidx_in  (lk_fidx[k]),
			.valid_out(lk_valid[k+1]),
			.row_out  (lk_row[k+1]),
			.found_out(lk_found[k+1]),
			.fidx_out (lk_fidx[k+1])
		);
	end

	vdr_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_VERTICES)
	) u_canon_map (
		.clk  (clk),
		.we   (state_q == vdr_pkg::VDR_WRITE),
		.waddr(idx_q),
		.wdata(canon),
		.raddr(ci_q[IDX_W-1:0]),
		.rdata(map_rdata)
	);

	assign item_stall = (state_q != vdr_pkg::VDR_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

endmodule

FILE: src/vdr_checker.sv
// ----------------------------------------------------------------------------
// vdr_checker
// Port-level checks of the vertex dedup block, bound to its top level.
// ----------------------------------------------------------------------------
`include "vertex_dedup_index_remap_assert.svh"

module vdr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input vdr_pkg::vdr_item_t item,
	input logic               res_valid,
	input logic               res_stall,
	input vdr_pkg::vdr_res_t  res
);

	// A result held under stall keeps its value.
	`VDR_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

	// A corner request keeps the input stalled while it is answered.
	`VDR_ASSERT_NXT(a_busy_after_req, item_valid && !item_stall && item.kind == vdr_pkg::VDR_KIND_CORNER, item_stall, "request taken while busy")

	// A vertex request never produces a result.
	`VDR_ASSERT_NXT(a_vertex_silent, item_valid && !item_stall && item.kind == vdr_pkg::VDR_KIND_VERTEX && !res_valid, !res_valid, "result after a vertex request")

	// With the result register free, a corner answer shows after the CADDR and CDATA states.
	`VDR_ASSERT_NOW(a_corner_latency, item_valid && !item_stall && item.kind == vdr_pkg::VDR_KIND_CORNER && !res_valid, 1'b1 ##3 res_valid, "corner result late")

endmodule

bind vertex_dedup_index_remap vdr_checker u_vdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item      (item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

FILE: tb/vertex_dedup_index_remap_checker.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap_checker
// Watches both channels of the vertex dedup block, keeps its own copy of the
// vertex store, and compares every remap result with the predicted one.
// ----------------------------------------------------------------------------
module vertex_dedup_index_remap_checker #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  vdr_pkg::vdr_item_t item,
	input  logic               res_valid,
	input  logic               res_stall,
	input  vdr_pkg::vdr_res_t  res,
	output int unsigned        mismatches,
	output int unsigned        outstanding,
	output int unsigned        checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import vdr_pkg::*;

	vdr_vertex_t mesh_vertices [MAX_VERTICES];
	logic [15:0] lowest_twin [MAX_VERTICES];
	int unsigned loaded = 0;
	vdr_res_t    remaps_due [$];

	// A NaN has an all-ones exponent and a nonzero fraction; it matches nothing.
	function automatic bit same_coord(input logic [31:0] a, input logic [31:0] b);
		bit a_nan;
		bit b_nan;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (a_nan || b_nan)
			return 1'b0;
		return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
	endfunction

	task automatic absorb_vertex(input vdr_item_t req);
		int unsigned slot;
		int unsigned canon;
		if (req.new_mesh)
			loaded = 0;
		// A full store drops the vertex without any trace.
		if (loaded >= MAX_VERTICES)
			return;
		slot  = loaded;
		canon = slot;
		for (int unsigned i = 0; i < slot; i++) begin
			if (same_coord(mesh_vertices[i].x, req.coord_x) &&
			    same_coord(mesh_vertices[i].y, req.coord_y) &&
			    same_coord(mesh_vertices[i].z, req.coord_z)) begin
				canon = i;
				break;
			end
		end
		mesh_vertices[slot].x = req.coord_x;
		mesh_vertices[slot].y = req.coord_y;
		mesh_vertices[slot].z = req.coord_z;
		lowest_twin[slot]     = canon[15:0];
		loaded                = slot + 1;
	endtask

	function automatic vdr_res_t remap_corner(input logic [15:0] ci);
		vdr_res_t r;
		r.remapped_index = (ci < loaded) ? lowest_twin[ci] : ci;
		r.was_merged     = (r.remapped_index != ci);
		return r;
	endfunction

	// Results are compared before the request of the same edge is absorbed; a
	// corner request never answers within the cycle it is accepted.
	always @(posedge clk) begin
		vdr_res_t want;
		if (!arst_n) begin
			mismatches  = 0;
			outstanding = 0;
			checked     = 0;
			loaded      = 0;
			remaps_due.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (remaps_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, actual index %0d merged %0b",
						$time, res.remapped_index, res.was_merged);
				end else begin
					want = remaps_due.pop_front();
					checked++;
					if (res !== want) begin
						mismatches++;
						$display("%0t: remap mismatch: expected index %0d merged %0b, actual index %0d merged %0b",
							$time, want.remapped_index, want.was_merged,
							res.remapped_index, res.was_merged);
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (item.kind == VDR_KIND_VERTEX)
					absorb_vertex(item);
				else
					remaps_due.push_back(remap_corner(item.corner_index));
			end
			outstanding = remaps_due.size();
		end
	end

endmodule

FILE: tb/vertex_dedup_index_remap_tb.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap_tb
// Drives vertex and corner requests into the vertex dedup block and lets the
// checker predict every remapped index. Directed cases cover signed zeros,
// NaNs, infinities, unloaded corners and a fresh mesh; random meshes with
// reused vertices follow, one of them filled past the store size.
// ----------------------------------------------------------------------------
module vertex_dedup_index_remap_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vdr_pkg::*;

	localparam int NUM_VERTS    = 1024;
	localparam int TARGET_ITEMS = 1400;
	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 100;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	vdr_item_t   item;
	logic        res_valid;
	logic        res_stall;
	vdr_res_t    res;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned checked;

	int unsigned idle_pct = 20;
	int unsigned items_sent = 0;
	int unsigned vertices_sent = 0;
	int unsigned corners_sent = 0;
	int unsigned refused = 0;
	int unsigned loaded = 0;
	int unsigned meshes = 0;
	bit          hold_go = 1'b0;
	vdr_vertex_t seen [$];

	vertex_dedup_index_remap #(
		.MAX_VERTICES(NUM_VERTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	vertex_dedup_index_remap_checker #(
		.MAX_VERTICES(NUM_VERTS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", cycles);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic vdr_vertex_t vtx(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		vdr_vertex_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		return v;
	endfunction

	// Coordinates lean on a few values so that distinct vertices collide.
	function automatic logic [31:0] pick_coord();
		logic [31:0] c;
		c = $urandom();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7FC0_0000;
			3: return {c[31], 8'hFF, 23'd0};
			4: return {c[31], 8'hFF, c[22:1], 1'b1};
			5: return 32'hFFFF_FFFF;
			6, 7: return 32'h3F80_0000;
			8: return 32'hBF80_0000;
			default: return c;
		endcase
	endfunction

	function automatic vdr_vertex_t next_vertex();
		vdr_vertex_t v;
		if (seen.size() > 0 && $urandom_range(0, 2) == 0) begin
			v = seen[$urandom_range(0, seen.size() - 1)];
			// Flip the sign of zeros so that the copy differs in bits only.
			if (v.x[30:0] == 31'd0 && $urandom_range(0, 1)) v.x[31] = ~v.x[31];
			if (v.y[30:0] == 31'd0 && $urandom_range(0, 1)) v.y[31] = ~v.y[31];
			if (v.z[30:0] == 31'd0 && $urandom_range(0, 1)) v.z[31] = ~v.z[31];
		end else begin
			v = vtx(pick_coord(), pick_coord(), pick_coord());
		end
		return v;
	endfunction

	function automatic logic [15:0] pick_corner();
		logic [31:0] c;
		c = $urandom();
		case ($urandom_range(0, 9))
			0: return c[15:0];
			1: return loaded[15:0];
			default: return (loaded == 0) ? 16'd0 : 16'($urandom_range(0, loaded - 1));
		endcase
	endfunction

	// Entered and left at a falling edge; the request is held until accepted.
	task automatic drive_request(input vdr_item_t req);
		if ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item       <= req;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
	endtask

	task automatic send_vertex(input bit fresh, input vdr_vertex_t v);
		vdr_item_t req;
		req.kind         = VDR_KIND_VERTEX;
		req.new_mesh     = fresh;
		req.coord_x      = v.x;
		req.coord_y      = v.y;
		req.coord_z      = v.z;
		req.corner_index = 16'($urandom());
		drive_request(req);
		if (fresh) begin
			seen.delete();
			loaded = 0;
			meshes++;
		end
		if (loaded >= NUM_VERTS) begin
			refused++;
		end else begin
			seen.push_back(v);
			loaded++;
			items_sent++;
		end
		vertices_sent++;
	endtask

	task automatic send_corner(input logic [15:0] idx, input bit mesh_flag);
		vdr_item_t req;
		req.kind         = VDR_KIND_CORNER;
		req.new_mesh     = mesh_flag;
		req.coord_x      = $urandom();
		req.coord_y      = $urandom();
		req.coord_z      = $urandom();
		req.corner_index = idx;
		drive_request(req);
		items_sent++;
		corners_sent++;
	endtask

	// Result side: short random stalls, plus one long hold-off while corner
	// requests keep arriving so that the input side backs up.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned mesh_no;
		int unsigned n;
		int unsigned m;
		bit          big;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corners on an empty store pass straight through.
		send_corner(16'd0, 1'b0);
		send_corner(16'hFFFF, 1'b0);
		send_vertex(1'b1, vtx(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
		send_vertex(1'b0, vtx(32'h8000_0000, 32'h0000_0000, 32'h8000_0000));
		send_vertex(1'b0, vtx(32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000));
		send_vertex(1'b0, vtx(32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000));
		send_vertex(1'b0, vtx(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF));
		send_vertex(1'b0, vtx(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF));
		send_vertex(1'b0, vtx(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_vertex(1'b0, vtx(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000));
		send_vertex(1'b0, vtx(32'h3F80_0000, 32'h4000_0000, 32'hC040_0000));
		send_vertex(1'b0, vtx(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000));
		for (int unsigned i = 1; i <= 10; i++)
			send_corner(16'(i), i == 5);
		// A vertex appended after corners still finds its earliest twin.
		send_vertex(1'b0, vtx(32'h8000_0000, 32'h8000_0000, 32'h0000_0000));
		send_corner(16'd10, 1'b0);
		send_vertex(1'b1, vtx(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000));
		send_corner(16'd1, 1'b0);

		mesh_no = 0;
		while (items_sent < TARGET_ITEMS) begin
			big = (mesh_no == 2);
			if (items_sent + 150 >= TARGET_ITEMS) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 25;
					default: idle_pct = 40;
				endcase
			end
			// One mesh runs past the store size; the rest stay small.
			n = big ? NUM_VERTS + 4 : $urandom_range(1, 40);
			send_vertex(1'b1, next_vertex());
			for (int unsigned i = 1; i < n; i++)
				send_vertex(!big && $urandom_range(0, 49) == 0, next_vertex());
			if (big) begin
				send_corner(16'(NUM_VERTS - 1), 1'b0);
				send_corner(16'(NUM_VERTS), 1'b0);
			end
			m = big ? 60 : (mesh_no == 1 ? 30 : $urandom_range(4, 30));
			if (mesh_no == 1)
				hold_go = 1'b1;
			for (int unsigned i = 0; i < m; i++) begin
				if (!big && $urandom_range(0, 9) == 0)
					send_vertex(1'b0, next_vertex());
				else
					send_corner(pick_corner(), $urandom_range(0, 1));
			end
			mesh_no++;
		end
		item_valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d vertex requests over %0d meshes (%0d refused on a full store)",
			vertices_sent, meshes, refused);
		$display("and %0d corner requests, %0d remaps checked, with one %0d-cycle result hold-off.",
			corners_sent, checked, HOLD_CYCLES);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: vertex_dedup_index_remap.f
+incdir+src
src/vdr_pkg.sv
src/vdr_ram.sv
src/vdr_cell.sv
src/vertex_dedup_index_remap.sv
src/vdr_checker.sv
tb/vertex_dedup_index_remap_checker.sv
tb/vertex_dedup_index_remap_tb.sv
